// ===== hw/rtl/pdee_pkg.sv =====
`default_nettype none
package pdee_pkg;

	localparam int QueueDepthDef = 64;
	localparam int MaxOut = 64;
	localparam int NW = $clog2(MaxOut + 1);

	// input operations
	typedef enum logic [2:0] {
		OP_MOTION  = 3'd0,
		OP_BUTTON  = 3'd1,
		OP_INJECT  = 3'd2,
		OP_CALL    = 3'd3,
		OP_DELIVER = 3'd4
	} op_t;

	// result kinds
	localparam logic [1:0] KIND_REPLY    = 2'd0;
	localparam logic [1:0] KIND_CALLBACK = 2'd1;
	localparam logic [1:0] KIND_UNSUP    = 2'd2;

	typedef struct packed {
		logic [2:0]         operation;
		logic [15:0]        func_code;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [1:0]         button_index;
		logic               pressed;
		logic [2:0]         button_mask;
		logic [15:0]        arg_bx;
		logic [15:0]        arg_cx;
		logic [15:0]        arg_dx;
		logic [15:0]        arg_es;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] reg_ax;
		logic [15:0] reg_bx;
		logic [15:0] reg_cx;
		logic [15:0] reg_dx;
		logic [15:0] reg_es;
		logic [15:0] reg_si;
		logic [15:0] reg_di;
		logic [15:0] target_seg;
		logic [15:0] target_off;
		logic        last;
	} out_item_t;

	// controller to datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_SCALE,
		CMD_STORE,
		CMD_INJ_POS,
		CMD_MOVE,
		CMD_BTN,
		CMD_CALL,
		CMD_DLV_START,
		CMD_DLV_READ,
		CMD_DLV_HOLD,
		CMD_DLV_EMIT,
		CMD_DLV_FLUSH
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic       axis;
		logic [1:0] btn;
		logic       from_mask;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic ready;
		logic no_handler;
		logic fifo_empty;
		logic n_full;
		logic ev_hit;
		logic pend_v;
		logic out_full;
	} stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pointer_driver_event_engine.sv =====
// Sequence: a driver call is latched, then its reply is loaded into the result register once that
// register is free, and the input is free again. Motion scales each axis in the shared divider
// or bypasses it for an unscaled axis, then moves; inject sets the position, then button edges.
// Deliver reads each queued edge through the edge queue's registered read port, then evaluates it.
// One item is worked at a time; the result register frees the next item as soon as loaded.
// Reset: asynchronous, clears driver state and the edge queue count, host size 640x200;
// queue entries need no clearing pass.
`default_nettype none
module pointer_driver_event_engine #(
	parameter int QUEUE_DEPTH = pdee_pkg::QueueDepthDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire pdee_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output pdee_pkg::out_item_t      out_item,
	input  wire logic                wr_en,
	input  wire logic                wr_index,
	input  wire logic [12:0]         wr_data
);
	import pdee_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pdee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_op    (in_item.operation),
		.in_btn   (in_item.button_index),
		.stat     (stat),
		.cmd      (cmd)
	);

	pdee_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.stat      (stat)
	);

	// divider is idle whenever a new item may enter
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.div_busy) else $error("divider busy while idle");

	// no callback left pending once deliver has finished
	a_pend_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.pend_v) else $error("pending callback left behind");

	// replies close their item
	a_reply_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.kind != KIND_CALLBACK) |-> out_item.last)
		else $error("reply without last");

	// callbacks always target a handler
	a_cb_target: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.kind == KIND_CALLBACK)
		|-> (out_item.target_seg != 16'd0 || out_item.target_off != 16'd0))
		else $error("callback without handler");
endmodule
`default_nettype wire

// ===== hw/rtl/pdee_ram.sv =====
`default_nettype none
module pdee_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/pdee_ctrl.sv =====
`default_nettype none
module pdee_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [2:0]      in_op,
	input  wire logic [1:0]      in_btn,
	input  wire pdee_pkg::stat_t stat,
	output pdee_pkg::cmd_t       cmd
);
	import pdee_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SCALE_X, S_WAIT_X, S_SCALE_Y, S_WAIT_Y, S_MOVE, S_INJ, S_BTN,
		S_CALL, S_D_START, S_D_CHECK, S_D_EVAL, S_D_FLUSH
	} state_t;

	state_t     state_q;
	logic [1:0] btn_q;
	logic       inj_q;

	assign in_ready = (state_q == S_IDLE);

	// decode commands from state and status
	always_comb begin
		cmd.op = CMD_NONE;
		cmd.axis = 1'b0;
		cmd.btn = btn_q;
		cmd.from_mask = inj_q;
		unique case (state_q)
			S_IDLE: if (in_valid) cmd.op = CMD_LATCH;
			S_SCALE_X: cmd.op = CMD_SCALE;
			S_WAIT_X: if (!stat.div_busy) cmd.op = CMD_STORE;
			S_SCALE_Y: begin
				cmd.op = CMD_SCALE;
				cmd.axis = 1'b1;
			end
			S_WAIT_Y: begin
				cmd.axis = 1'b1;
				if (!stat.div_busy) cmd.op = CMD_STORE;
			end
			S_MOVE: cmd.op = CMD_MOVE;
			S_INJ: cmd.op = CMD_INJ_POS;
			S_BTN: cmd.op = CMD_BTN;
			S_CALL: if (!stat.out_full) cmd.op = CMD_CALL;
			S_D_START: cmd.op = CMD_DLV_START;
			S_D_CHECK: if (!(stat.fifo_empty || stat.n_full)) cmd.op = CMD_DLV_READ;
			S_D_EVAL: begin
				if (stat.ev_hit) begin
					if (!stat.pend_v) cmd.op = CMD_DLV_HOLD;
					else if (!stat.out_full) cmd.op = CMD_DLV_EMIT;
				end
			end
			S_D_FLUSH: if (!stat.out_full) cmd.op = CMD_DLV_FLUSH;
			default: cmd.op = CMD_NONE;
		endcase
	end

	// advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			btn_q <= '0;
			inj_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						inj_q <= 1'b0;
						btn_q <= in_btn;
						case (in_op)
							OP_MOTION: state_q <= S_SCALE_X;
							OP_BUTTON: state_q <= S_BTN;
							OP_INJECT: state_q <= S_INJ;
							OP_CALL: state_q <= S_CALL;
							OP_DELIVER: state_q <= S_D_START;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SCALE_X: state_q <= S_WAIT_X;
				S_WAIT_X: if (!stat.div_busy) state_q <= S_SCALE_Y;
				S_SCALE_Y: state_q <= S_WAIT_Y;
				S_WAIT_Y: if (!stat.div_busy) state_q <= S_MOVE;
				S_MOVE: begin
					btn_q <= '0;
					state_q <= inj_q ? S_BTN : S_IDLE;
				end
				S_INJ: begin
					inj_q <= 1'b1;
					state_q <= S_MOVE;
				end
				S_BTN: begin
					if (inj_q && btn_q != 2'd2) btn_q <= btn_q + 2'd1;
					else state_q <= S_IDLE;
				end
				S_CALL: if (!stat.out_full) state_q <= S_IDLE;
				S_D_START: begin
					if (!stat.ready || stat.no_handler) state_q <= S_IDLE;
					else state_q <= S_D_CHECK;
				end
				S_D_CHECK: begin
					if (stat.fifo_empty || stat.n_full)
						state_q <= stat.pend_v ? S_D_FLUSH : S_IDLE;
					else
						state_q <= S_D_EVAL;
				end
				S_D_EVAL: begin
					if (!stat.ev_hit || !stat.pend_v || !stat.out_full) state_q <= S_D_CHECK;
				end
				S_D_FLUSH: if (!stat.out_full) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/pdee_dp.sv =====
`default_nettype none
module pdee_dp #(
	parameter int QUEUE_DEPTH = pdee_pkg::QueueDepthDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pdee_pkg::in_item_t  in_item,
	input  wire pdee_pkg::cmd_t      cmd,
	input  wire logic                wr_en,
	input  wire logic                wr_index,
	input  wire logic [12:0]         wr_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output pdee_pkg::out_item_t      out_item,
	output pdee_pkg::stat_t          stat
);
	import pdee_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = 74;

	function automatic logic [15:0] clampw(input logic signed [34:0] v,
		input logic [15:0] lo, input logic [15:0] hi);
		logic signed [34:0] l;
		logic signed [34:0] h;
		l = $signed({{19{lo[15]}}, lo});
		h = $signed({{19{hi[15]}}, hi});
		if (v < l) return lo;
		if (v > h) return hi;
		return v[15:0];
	endfunction

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic signed [34:0] sx35(input logic [15:0] v);
		return $signed({{19{v[15]}}, v});
	endfunction

	in_item_t item_q;
	logic [12:0] host_w_q, host_h_q;
	logic [15:0] cur_x_q, cur_y_q, show_q;
	logic [2:0]  bdown_q;
	logic [15:0] win_q [4];
	logic [15:0] mick_q [2];
	logic [15:0] ptal_q [3];
	logic [15:0] rtal_q [3];
	logic [31:0] pwh_q [3];
	logic [31:0] rwh_q [3];
	logic [15:0] cb_seg_q, cb_off_q, cb_mask_q;
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] cnt_q;
	logic rdy_q;

	// divider
	logic signed [33:0] prod_q;
	logic        neg_q, byp_q;
	logic [32:0] quo_q;
	logic [13:0] rem_q;
	logic [12:0] dsr_q;
	logic [5:0]  dcnt_q;
	logic [15:0] nx_q, ny_q;

	// deliver
	logic [NW-1:0] n_q;
	logic          pend_v_q, out_v_q;
	out_item_t     pend_q, out_q;

	// scale operands
	logic signed [15:0] raw_c;
	logic [15:0] lo_c, hi_c;
	logic [12:0] size_c;
	logic signed [16:0] sraw_c, diff_c;
	logic signed [33:0] prod_c;
	logic [33:0] mag_c;
	logic [13:0] rsh_c;
	logic signed [34:0] sum_c;
	logic [15:0] scl_c;

	assign raw_c = cmd.axis ? item_q.pos_y : item_q.pos_x;
	assign lo_c = win_q[{cmd.axis, 1'b0}];
	assign hi_c = win_q[{cmd.axis, 1'b1}];
	assign size_c = cmd.axis ? host_h_q : host_w_q;
	assign sraw_c = {raw_c[15], raw_c};
	assign diff_c = $signed({hi_c[15], hi_c}) - $signed({lo_c[15], lo_c});
	assign prod_c = sraw_c * diff_c;
	assign mag_c = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
	assign rsh_c = {rem_q[12:0], quo_q[32]};
	assign sum_c = byp_q ? 35'(sraw_c)
		: sx35(lo_c) + (neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}));
	assign scl_c = clampw(sum_c, lo_c, hi_c);

	// edge push
	logic        mv_chg, b_ok, b_down, b_eff, push_c;
	logic [2:0]  b_bit, b_new;
	logic [15:0] ddx, ddy;
	logic [6:0]  e_mask;
	logic [EW-1:0] e_data;

	assign mv_chg = (nx_q != cur_x_q) || (ny_q != cur_y_q);
	assign ddx = nx_q - cur_x_q;
	assign ddy = ny_q - cur_y_q;
	assign b_ok = (cmd.btn != 2'd3);
	assign b_down = cmd.from_mask ? item_q.button_mask[cmd.btn] : item_q.pressed;
	assign b_bit = 3'b001 << cmd.btn;
	assign b_eff = b_down ? ((bdown_q & b_bit) == 3'b000) : ((bdown_q & b_bit) != 3'b000);
	assign b_new = b_down ? (bdown_q | b_bit) : (bdown_q & ~b_bit);
	assign e_mask = b_down ? (7'b0000010 << {cmd.btn, 1'b0}) : (7'b0000100 << {cmd.btn, 1'b0});

	always_comb begin
		push_c = 1'b0;
		e_data = '0;
		if (cmd.op == CMD_MOVE && mv_chg) begin
			push_c = 1'b1;
			e_data = {7'b0000001, bdown_q, nx_q, ny_q, ddx, ddy};
		end else if (cmd.op == CMD_BTN && b_ok && b_eff) begin
			push_c = 1'b1;
			e_data = {e_mask, b_new, cur_x_q, cur_y_q, 32'd0};
		end
	end

	logic [EW-1:0] rdata;
	logic [15:0]   ev_c;
	out_item_t     new_o;

	pdee_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (push_c),
		.waddr (tail_q),
		.wdata (e_data),
		.re    (cmd.op == CMD_DLV_READ),
		.raddr (head_q),
		.rdata (rdata)
	);

	// callback built from the head entry
	assign ev_c = {9'd0, rdata[73:67] & cb_mask_q[6:0]};
	always_comb begin
		new_o.kind = KIND_CALLBACK;
		new_o.reg_ax = ev_c;
		new_o.reg_bx = {13'd0, rdata[66:64]};
		new_o.reg_cx = rdata[63:48];
		new_o.reg_dx = rdata[47:32];
		new_o.reg_es = '0;
		new_o.reg_si = rdata[31:16];
		new_o.reg_di = rdata[15:0];
		new_o.target_seg = cb_seg_q;
		new_o.target_off = cb_off_q;
		new_o.last = 1'b0;
	end

	// window set operands
	logic        wax;
	logic [15:0] wlo, whi;
	logic [1:0]  pb;
	assign wax = (item_q.func_code == 16'h0008);
	assign wlo = ($signed(item_q.arg_cx) <= $signed(item_q.arg_dx)) ? item_q.arg_cx : item_q.arg_dx;
	assign whi = ($signed(item_q.arg_cx) <= $signed(item_q.arg_dx)) ? item_q.arg_dx : item_q.arg_cx;
	assign pb = (item_q.arg_bx <= 16'd2) ? item_q.arg_bx[1:0] : 2'd0;

	// driver call reply
	out_item_t reply_c;
	always_comb begin
		reply_c.kind = KIND_REPLY;
		reply_c.reg_ax = item_q.func_code;
		reply_c.reg_bx = item_q.arg_bx;
		reply_c.reg_cx = item_q.arg_cx;
		reply_c.reg_dx = item_q.arg_dx;
		reply_c.reg_es = item_q.arg_es;
		reply_c.reg_si = '0;
		reply_c.reg_di = '0;
		reply_c.target_seg = '0;
		reply_c.target_off = '0;
		reply_c.last = 1'b1;
		case (item_q.func_code)
			16'h0000, 16'h0021: begin
				reply_c.reg_ax = 16'hFFFF;
				reply_c.reg_bx = 16'd2;
			end
			16'h0003: begin
				reply_c.reg_bx = {13'd0, bdown_q};
				reply_c.reg_cx = cur_x_q;
				reply_c.reg_dx = cur_y_q;
			end
			16'h0005: begin
				reply_c.reg_ax = {13'd0, bdown_q};
				reply_c.reg_bx = ptal_q[pb];
				reply_c.reg_cx = pwh_q[pb][31:16];
				reply_c.reg_dx = pwh_q[pb][15:0];
			end
			16'h0006: begin
				reply_c.reg_ax = {13'd0, bdown_q};
				reply_c.reg_bx = rtal_q[pb];
				reply_c.reg_cx = rwh_q[pb][31:16];
				reply_c.reg_dx = rwh_q[pb][15:0];
			end
			16'h000B: begin
				reply_c.reg_cx = mick_q[0];
				reply_c.reg_dx = mick_q[1];
			end
			16'h0014: begin
				reply_c.reg_cx = cb_mask_q;
				reply_c.reg_dx = cb_off_q;
				reply_c.reg_es = cb_seg_q;
			end
			16'h001B: begin
				reply_c.reg_bx = 16'd50;
				reply_c.reg_cx = 16'd50;
				reply_c.reg_dx = 16'd50;
			end
			16'h001E: reply_c.reg_bx = '0;
			16'h0024: begin
				reply_c.reg_bx = 16'h0700;
				reply_c.reg_cx = 16'h0400;
			end
			16'h0001, 16'h0002, 16'h0004, 16'h0007, 16'h0008, 16'h000C,
			16'h0009, 16'h000A, 16'h000D, 16'h000E, 16'h000F,
			16'h0010, 16'h0013, 16'h001A, 16'h001C, 16'h001D: ;
			default: reply_c.kind = KIND_UNSUP;
		endcase
	end

	// final callback of a deliver closes it
	out_item_t flush_c;
	always_comb begin
		flush_c = pend_q;
		flush_c.last = 1'b1;
	end

	assign stat.div_busy = (dcnt_q != '0);
	assign stat.ready = rdy_q;
	assign stat.no_handler = (cb_seg_q == '0) && (cb_off_q == '0);
	assign stat.fifo_empty = (cnt_q == '0);
	assign stat.n_full = (n_q == NW'(MaxOut));
	assign stat.ev_hit = (ev_c != '0);
	assign stat.pend_v = pend_v_q;
	assign stat.out_full = out_v_q;

	assign out_valid = out_v_q;
	assign out_item = out_q;

	// latch item and run the divider
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_LATCH) item_q <= in_item;
		if (cmd.op == CMD_SCALE) begin
			prod_q <= prod_c;
			byp_q <= (size_c <= 13'd1);
			dsr_q <= size_c - 13'd1;
		end
		if (dcnt_q == 6'd34) begin
			quo_q <= mag_c[32:0];
			neg_q <= prod_q[33];
			rem_q <= '0;
		end else if (dcnt_q != '0) begin
			if (rsh_c >= {1'b0, dsr_q}) begin
				rem_q <= rsh_c - {1'b0, dsr_q};
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= rsh_c;
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
		if (cmd.op == CMD_STORE) begin
			if (cmd.axis) ny_q <= scl_c;
			else nx_q <= scl_c;
		end
		if (cmd.op == CMD_INJ_POS) begin
			nx_q <= clampw(sx35(item_q.pos_x), win_q[0], win_q[1]);
			ny_q <= clampw(sx35(item_q.pos_y), win_q[2], win_q[3]);
		end
		if (cmd.op == CMD_DLV_HOLD || cmd.op == CMD_DLV_EMIT) pend_q <= new_o;
		// load the result register
		if (cmd.op == CMD_CALL) out_q <= reply_c;
		else if (cmd.op == CMD_DLV_EMIT) out_q <= pend_q;
		else if (cmd.op == CMD_DLV_FLUSH) out_q <= flush_c;
	end

	// driver state, queue pointers and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_w_q <= 13'd640;
			host_h_q <= 13'd200;
			cur_x_q <= '0;
			cur_y_q <= '0;
			show_q <= '0;
			bdown_q <= '0;
			for (int i = 0; i < 4; i++) win_q[i] <= '0;
			for (int i = 0; i < 2; i++) mick_q[i] <= '0;
			for (int i = 0; i < 3; i++) begin
				ptal_q[i] <= '0;
				rtal_q[i] <= '0;
				pwh_q[i] <= '0;
				rwh_q[i] <= '0;
			end
			cb_seg_q <= '0;
			cb_off_q <= '0;
			cb_mask_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			rdy_q <= 1'b0;
			dcnt_q <= '0;
			n_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (wr_en) begin
				if (wr_index) host_h_q <= wr_data;
				else host_w_q <= wr_data;
			end
			if (out_v_q && out_ready) out_v_q <= 1'b0;

			// divider count
			if (cmd.op == CMD_SCALE) dcnt_q <= (size_c <= 13'd1) ? 6'd0 : 6'd34;
			else if (dcnt_q != '0) dcnt_q <= dcnt_q - 6'd1;

			// queue an edge, dropping the oldest when full
			if (push_c) begin
				tail_q <= nxt(tail_q);
				if (cnt_q == CW'(QUEUE_DEPTH)) head_q <= nxt(head_q);
				else cnt_q <= cnt_q + CW'(1);
			end

			if (cmd.op == CMD_MOVE && mv_chg) begin
				mick_q[0] <= mick_q[0] + ddx;
				mick_q[1] <= mick_q[1] + ddy;
				cur_x_q <= nx_q;
				cur_y_q <= ny_q;
			end

			if (cmd.op == CMD_BTN && b_ok && b_eff) begin
				bdown_q <= b_new;
				if (b_down) begin
					ptal_q[cmd.btn] <= ptal_q[cmd.btn] + 16'd1;
					pwh_q[cmd.btn] <= {cur_x_q, cur_y_q};
				end else begin
					rtal_q[cmd.btn] <= rtal_q[cmd.btn] + 16'd1;
					rwh_q[cmd.btn] <= {cur_x_q, cur_y_q};
				end
			end

			if (cmd.op == CMD_CALL) begin
				out_v_q <= 1'b1;
				case (item_q.func_code)
					16'h0000, 16'h0021: begin
						bdown_q <= '0;
						for (int i = 0; i < 2; i++) mick_q[i] <= '0;
						for (int i = 0; i < 3; i++) begin
							ptal_q[i] <= '0;
							rtal_q[i] <= '0;
							pwh_q[i] <= '0;
							rwh_q[i] <= '0;
						end
						cb_seg_q <= '0;
						cb_off_q <= '0;
						cb_mask_q <= '0;
						head_q <= '0;
						tail_q <= '0;
						cnt_q <= '0;
						win_q[0] <= '0;
						win_q[1] <= 16'd639;
						win_q[2] <= '0;
						win_q[3] <= 16'd199;
						cur_x_q <= 16'd319;
						cur_y_q <= 16'd99;
						show_q <= 16'hFFFF;
						rdy_q <= 1'b1;
					end
					16'h0001: if (show_q[15]) show_q <= show_q + 16'd1;
					16'h0002: show_q <= show_q - 16'd1;
					16'h0004: begin
						cur_x_q <= clampw(sx35(item_q.arg_cx), win_q[0], win_q[1]);
						cur_y_q <= clampw(sx35(item_q.arg_dx), win_q[2], win_q[3]);
					end
					16'h0005: ptal_q[pb] <= '0;
					16'h0006: rtal_q[pb] <= '0;
					16'h0007, 16'h0008: begin
						win_q[{wax, 1'b0}] <= wlo;
						win_q[{wax, 1'b1}] <= whi;
						if (wax) cur_y_q <= clampw(sx35(cur_y_q), wlo, whi);
						else cur_x_q <= clampw(sx35(cur_x_q), wlo, whi);
					end
					16'h000B: begin
						mick_q[0] <= '0;
						mick_q[1] <= '0;
					end
					16'h000C, 16'h0014: begin
						cb_mask_q <= item_q.arg_cx;
						cb_off_q <= item_q.arg_dx;
						cb_seg_q <= item_q.arg_es;
					end
					default: ;
				endcase
			end

			// deliver: start, pop, hold, emit and flush
			if (cmd.op == CMD_DLV_START) begin
				n_q <= '0;
				pend_v_q <= 1'b0;
				if (rdy_q && cb_seg_q == '0 && cb_off_q == '0) begin
					head_q <= '0;
					tail_q <= '0;
					cnt_q <= '0;
				end
			end
			if (cmd.op == CMD_DLV_READ) begin
				head_q <= nxt(head_q);
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.op == CMD_DLV_HOLD) begin
				pend_v_q <= 1'b1;
				n_q <= n_q + NW'(1);
			end
			if (cmd.op == CMD_DLV_EMIT) begin
				out_v_q <= 1'b1;
				n_q <= n_q + NW'(1);
			end
			if (cmd.op == CMD_DLV_FLUSH) begin
				out_v_q <= 1'b1;
				pend_v_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import pdee_pkg::*;

	localparam int FIFO_SLOTS = 64;
	localparam int CALLBACK_CAP = 64;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 200;

	localparam logic [15:0] FN_RESET     = 16'h0000;
	localparam logic [15:0] FN_SHOW      = 16'h0001;
	localparam logic [15:0] FN_HIDE      = 16'h0002;
	localparam logic [15:0] FN_GET_POS   = 16'h0003;
	localparam logic [15:0] FN_SET_POS   = 16'h0004;
	localparam logic [15:0] FN_PRESS     = 16'h0005;
	localparam logic [15:0] FN_RELEASE   = 16'h0006;
	localparam logic [15:0] FN_WIN_X     = 16'h0007;
	localparam logic [15:0] FN_WIN_Y     = 16'h0008;
	localparam logic [15:0] FN_MICKEYS   = 16'h000B;
	localparam logic [15:0] FN_SET_HDL   = 16'h000C;
	localparam logic [15:0] FN_SWAP_HDL  = 16'h0014;
	localparam logic [15:0] FN_SENS      = 16'h001B;
	localparam logic [15:0] FN_PAGE      = 16'h001E;
	localparam logic [15:0] FN_SW_RESET  = 16'h0021;
	localparam logic [15:0] FN_INFO      = 16'h0024;
	localparam logic [15:0] FN_SAVE_SIZE = 16'h0015;
	localparam logic [15:0] FN_NOP_A     = 16'h0009;
	localparam logic [15:0] FN_NOP_B     = 16'h001D;

	localparam logic REG_HOST_W = 1'b0;
	localparam logic REG_HOST_H = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic wr_en = 1'b0;
	logic wr_index = 1'b0;
	logic [12:0] wr_data = '0;

	pointer_driver_event_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [12:0] host_w, host_h;
	logic [15:0] cur_x, cur_y, show_lvl;
	logic [2:0]  btn_down;
	logic [15:0] win [4];
	logic [15:0] mick [2];
	logic [15:0] press_cnt [3], rel_cnt [3];
	logic [31:0] press_at [3], rel_at [3];
	logic [15:0] hdl_seg, hdl_off, hdl_mask;
	logic [41:0] edge_q_info [$];
	logic [31:0] edge_q_delta [$];
	logic drv_ready;

	out_item_t expected_beats [$];
	in_item_t pending_items [$];
	int mismatches = 0;
	int beats_seen = 0;
	int callbacks_seen = 0;
	int items_sent = 0;
	int cycles = 0;

	task automatic report(input string what, input out_item_t got, input out_item_t want);
		mismatches++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	function automatic logic [15:0] clamp16(input longint v, input logic [15:0] lo,
			input logic [15:0] hi);
		if (v < longint'($signed(lo))) return lo;
		if (v > longint'($signed(hi))) return hi;
		return v[15:0];
	endfunction

	function automatic void clear_driver();
		cur_x = 0; cur_y = 0; btn_down = 0; show_lvl = 0;
		for (int i = 0; i < 4; i++) win[i] = 0;
		mick[0] = 0; mick[1] = 0;
		for (int i = 0; i < 3; i++) begin
			press_cnt[i] = 0; rel_cnt[i] = 0; press_at[i] = 0; rel_at[i] = 0;
		end
		hdl_seg = 0; hdl_off = 0; hdl_mask = 0;
		edge_q_info.delete(); edge_q_delta.delete();
		drv_ready = 0;
	endfunction

	function automatic void queue_edge(input logic [6:0] mask, input logic [15:0] dx,
			input logic [15:0] dy);
		if (edge_q_info.size() >= FIFO_SLOTS) begin
			void'(edge_q_info.pop_front());
			void'(edge_q_delta.pop_front());
		end
		edge_q_info.push_back({mask, btn_down, cur_x, cur_y});
		edge_q_delta.push_back({dx, dy});
	endfunction

	function automatic void move_cursor(input logic [15:0] nx, input logic [15:0] ny);
		logic [15:0] ddx, ddy;
		if (nx != cur_x || ny != cur_y) begin
			ddx = nx - cur_x; ddy = ny - cur_y;
			mick[0] += ddx; mick[1] += ddy;
			cur_x = nx; cur_y = ny;
			queue_edge(7'd1, ddx, ddy);
		end
	endfunction

	function automatic void apply_button(input int b, input logic down);
		logic [2:0] bit_m;
		if (b > 2) return;
		bit_m = 3'b1 << b;
		if (down) begin
			if (btn_down & bit_m) return;
			btn_down |= bit_m;
			press_cnt[b]++;
			press_at[b] = {cur_x, cur_y};
			queue_edge(7'd1 << (1 + 2 * b), 0, 0);
		end else begin
			if (!(btn_down & bit_m)) return;
			btn_down &= ~bit_m;
			rel_cnt[b]++;
			rel_at[b] = {cur_x, cur_y};
			queue_edge(7'd1 << (2 + 2 * b), 0, 0);
		end
	endfunction

	function automatic logic [15:0] scale_host(input logic [15:0] raw, input logic [12:0] sz,
			input logic [15:0] lo, input logic [15:0] hi);
		longint v;
		v = $signed(raw);
		if (sz > 1)
			v = longint'($signed(lo)) + (v * (longint'($signed(hi)) - longint'($signed(lo))))
				/ longint'(sz - 1);
		return clamp16(v, lo, hi);
	endfunction

	function automatic void set_window(input int axis, input logic [15:0] a,
			input logic [15:0] b);
		if ($signed(a) <= $signed(b)) begin
			win[2 * axis] = a; win[2 * axis + 1] = b;
		end else begin
			win[2 * axis] = b; win[2 * axis + 1] = a;
		end
		if (axis == 0) cur_x = clamp16($signed(cur_x), win[0], win[1]);
		else cur_y = clamp16($signed(cur_y), win[2], win[3]);
	endfunction

	function automatic out_item_t run_call(input in_item_t it);
		out_item_t r;
		logic [15:0] ax, bx, cx, dx, es, os, oo, om;
		int b;
		ax = it.func_code; bx = it.arg_bx; cx = it.arg_cx; dx = it.arg_dx; es = it.arg_es;
		r = '0;
		r.kind = KIND_REPLY;
		case (ax)
			FN_RESET, FN_SW_RESET: begin
				clear_driver();
				win[1] = 639; win[3] = 199;
				cur_x = 319; cur_y = 99;
				show_lvl = 16'hFFFF;
				drv_ready = 1;
				ax = 16'hFFFF; bx = 2;
			end
			FN_SHOW: if (show_lvl[15]) show_lvl++;
			FN_HIDE: show_lvl--;
			FN_GET_POS: begin
				bx = {13'd0, btn_down}; cx = cur_x; dx = cur_y;
			end
			FN_SET_POS: begin
				cur_x = clamp16($signed(cx), win[0], win[1]);
				cur_y = clamp16($signed(dx), win[2], win[3]);
			end
			FN_PRESS, FN_RELEASE: begin
				b = (bx <= 2) ? int'(bx) : 0;
				ax = {13'd0, btn_down};
				if (it.func_code == FN_PRESS) begin
					{cx, dx} = press_at[b]; bx = press_cnt[b]; press_cnt[b] = 0;
				end else begin
					{cx, dx} = rel_at[b]; bx = rel_cnt[b]; rel_cnt[b] = 0;
				end
			end
			FN_WIN_X: set_window(0, cx, dx);
			FN_WIN_Y: set_window(1, cx, dx);
			FN_MICKEYS: begin
				cx = mick[0]; dx = mick[1]; mick[0] = 0; mick[1] = 0;
			end
			FN_SET_HDL: begin
				hdl_mask = cx; hdl_off = dx; hdl_seg = es;
			end
			FN_SWAP_HDL: begin
				os = hdl_seg; oo = hdl_off; om = hdl_mask;
				hdl_mask = cx; hdl_off = dx; hdl_seg = es;
				cx = om; dx = oo; es = os;
			end
			FN_SENS: begin
				bx = 50; cx = 50; dx = 50;
			end
			FN_PAGE: bx = 0;
			FN_INFO: begin
				bx = 16'h0700; cx = 16'h0400;
			end
			16'h0009, 16'h000A, 16'h000D, 16'h000E, 16'h000F,
			16'h0010, 16'h0013, 16'h001A, 16'h001C, 16'h001D: ;
			default: r.kind = KIND_UNSUP;
		endcase
		r.reg_ax = ax; r.reg_bx = bx; r.reg_cx = cx; r.reg_dx = dx; r.reg_es = es;
		r.last = 1'b1;
		return r;
	endfunction

	// work out the beats one accepted item causes
	function automatic void predict_item(input in_item_t it);
		out_item_t r;
		logic [41:0] info;
		logic [31:0] d;
		logic [6:0] ev;
		int n;
		case (it.operation)
			OP_MOTION: move_cursor(scale_host(it.pos_x, host_w, win[0], win[1]),
				scale_host(it.pos_y, host_h, win[2], win[3]));
			OP_BUTTON: apply_button(it.button_index, it.pressed);
			OP_INJECT: begin
				move_cursor(clamp16(it.pos_x, win[0], win[1]),
					clamp16(it.pos_y, win[2], win[3]));
				for (int b = 0; b < 3; b++) apply_button(b, it.button_mask[b]);
			end
			OP_CALL: expected_beats.push_back(run_call(it));
			OP_DELIVER: begin
				if (!drv_ready) return;
				if (hdl_seg == 0 && hdl_off == 0) begin
					edge_q_info.delete(); edge_q_delta.delete();
					return;
				end
				n = 0;
				while (edge_q_info.size() > 0 && n < CALLBACK_CAP) begin
					info = edge_q_info.pop_front();
					d = edge_q_delta.pop_front();
					ev = info[41:35] & hdl_mask[6:0];
					if (ev == 0) continue;
					r = '0;
					r.kind = KIND_CALLBACK;
					r.reg_ax = {9'd0, ev}; r.reg_bx = {13'd0, info[34:32]};
					r.reg_cx = info[31:16]; r.reg_dx = info[15:0];
					r.reg_si = d[31:16]; r.reg_di = d[15:0];
					r.target_seg = hdl_seg; r.target_off = hdl_off;
					expected_beats.push_back(r);
					n++;
				end
				if (n > 0) expected_beats[expected_beats.size() - 1].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// driver: bursts with random gaps; a hold entry pauses until all results are back
	int gap_left = 0;
	int burst_left = 0;
	logic hold_for_drain = 1'b0;
	logic in_hold [$];

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_item(in_item);
				items_sent++;
			end
			if (!(in_valid && !in_ready)) begin
				if (hold_for_drain) begin
					in_valid <= 1'b0;
					if (expected_beats.size() == 0 && !(in_valid && in_ready))
						hold_for_drain <= 1'b0;
				end else if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_items.size() > 0) begin
					if (in_hold.size() > 0 && in_hold[0]) begin
						void'(in_hold.pop_front());
						hold_for_drain <= 1'b1;
						in_valid <= 1'b0;
					end else begin
						void'(in_hold.pop_front());
						in_item <= pending_items.pop_front();
						in_valid <= 1'b1;
						if (burst_left > 0) burst_left <= burst_left - 1;
						else begin
							burst_left <= $urandom_range(0, 12);
							gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
						end
					end
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor: check each beat and stall on a pattern of its own
	int stall_phase = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				beats_seen++;
				if (out_item.kind == KIND_CALLBACK) callbacks_seen++;
				if (expected_beats.size() == 0)
					report("unexpected beat", out_item, '0);
				else begin
					out_item_t w;
					w = expected_beats.pop_front();
					if (out_item.kind != w.kind) report("kind", out_item, w);
					if (out_item.reg_ax != w.reg_ax) report("reg_ax", out_item, w);
					if (out_item.reg_bx != w.reg_bx) report("reg_bx", out_item, w);
					if (out_item.reg_cx != w.reg_cx) report("reg_cx", out_item, w);
					if (out_item.reg_dx != w.reg_dx) report("reg_dx", out_item, w);
					if (out_item.reg_es != w.reg_es) report("reg_es", out_item, w);
					if (out_item.reg_si != w.reg_si) report("reg_si", out_item, w);
					if (out_item.reg_di != w.reg_di) report("reg_di", out_item, w);
					if (out_item.target_seg != w.target_seg) report("target_seg", out_item, w);
					if (out_item.target_off != w.target_off) report("target_off", out_item, w);
					if (out_item.last != w.last) report("last", out_item, w);
				end
			end
			stall_phase <= (stall_phase + 1) % 97;
			if (stall_phase < 30) out_ready <= 1'b1;
			else if (stall_phase < 60) out_ready <= ($urandom_range(0, 3) != 0);
			else out_ready <= ($urandom_range(0, 2) == 0);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic in_item_t make_call(input logic [15:0] fn, input logic [15:0] bx,
			input logic [15:0] cx, input logic [15:0] dx, input logic [15:0] es);
		in_item_t it;
		it = '0;
		it.operation = OP_CALL;
		it.func_code = fn; it.arg_bx = bx; it.arg_cx = cx; it.arg_dx = dx; it.arg_es = es;
		return it;
	endfunction

	function automatic in_item_t make_pointer(input op_t op, input logic [15:0] x,
			input logic [15:0] y, input logic [1:0] b, input logic p, input logic [2:0] m);
		in_item_t it;
		it = '0;
		it.operation = op; it.pos_x = x; it.pos_y = y;
		it.button_index = b; it.pressed = p; it.button_mask = m;
		return it;
	endfunction

	function automatic in_item_t random_bits();
		logic [159:0] raw;
		in_item_t it;
		raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		it = raw[$bits(in_item_t)-1:0];
		return it;
	endfunction

	function automatic logic [15:0] random_fn();
		logic [15:0] fns [18];
		fns = '{FN_RESET, FN_SHOW, FN_HIDE, FN_GET_POS, FN_SET_POS, FN_PRESS, FN_RELEASE,
			FN_WIN_X, FN_WIN_Y, FN_MICKEYS, FN_SET_HDL, FN_SWAP_HDL, FN_SENS, FN_PAGE,
			FN_SW_RESET, FN_INFO, FN_NOP_A, FN_NOP_B};
		return fns[$urandom_range(0, 17)];
	endfunction

	// one random item, mostly pointer traffic and sensible driver calls
	function automatic in_item_t random_item();
		in_item_t it;
		int pick;
		it = random_bits();
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			it.operation = OP_MOTION;
			if ($urandom_range(0, 3) != 0) begin
				it.pos_x = 16'($urandom_range(0, 700));
				it.pos_y = 16'($urandom_range(0, 260));
			end
		end else if (pick < 45) it.operation = OP_BUTTON;
		else if (pick < 55) begin
			it.operation = OP_INJECT;
			if ($urandom_range(0, 2) != 0) begin
				it.pos_x = 16'($urandom_range(0, 700));
				it.pos_y = 16'($urandom_range(0, 260));
			end
		end else if (pick < 88) begin
			it.operation = OP_CALL;
			if ($urandom_range(0, 9) != 0) it.func_code = random_fn();
			if (it.func_code == FN_SET_HDL || it.func_code == FN_SWAP_HDL) begin
				if ($urandom_range(0, 4) != 0) it.arg_cx[6:0] = 7'h7F;
				if ($urandom_range(0, 9) == 0) begin
					it.arg_dx = 0; it.arg_es = 0;
				end
			end
			if (it.func_code == FN_PRESS || it.func_code == FN_RELEASE)
				it.arg_bx = 16'($urandom_range(0, 4));
		end else begin
			it.operation = OP_DELIVER;
		end
		if ($urandom_range(0, 99) == 0) it.operation = 3'($urandom_range(5, 7));
		return it;
	endfunction

	task automatic push(input in_item_t it, input logic hold);
		pending_items.push_back(it);
		in_hold.push_back(hold);
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || hold_for_drain
				|| expected_beats.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [12:0] val);
		@(posedge clk);
		wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_HOST_W) host_w = val; else host_h = val;
	endtask

	initial begin
		logic [12:0] w_set [5];
		logic [12:0] h_set [5];
		host_w = 640; host_h = 200;
		clear_driver();
		w_set = '{13'd640, 13'd0, 13'd1, 13'd4096, 13'd8191};
		h_set = '{13'd200, 13'd1, 13'd0, 13'd4096, 13'd8191};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: calls before reset, reset, edges, handler and deliver
		push(make_pointer(OP_DELIVER, 0, 0, 0, 0, 0), 1'b0);
		push(make_call(FN_GET_POS, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
		push(make_call(FN_RESET, 0, 0, 0, 0), 1'b0);
		push(make_pointer(OP_MOTION, 16'h7FFF, 16'h8000, 0, 0, 0), 1'b0);
		push(make_pointer(OP_MOTION, 16'h8000, 16'h7FFF, 0, 0, 0), 1'b0);
		push(make_pointer(OP_BUTTON, 0, 0, 2'd0, 1'b1, 0), 1'b0);
		push(make_pointer(OP_BUTTON, 0, 0, 2'd0, 1'b1, 0), 1'b0);
		push(make_pointer(OP_BUTTON, 0, 0, 2'd3, 1'b1, 0), 1'b0);
		push(make_pointer(OP_INJECT, 16'd100, 16'd50, 0, 0, 3'b110), 1'b0);
		push(make_call(FN_SET_HDL, 0, 16'h007F, 16'h1234, 16'hABCD), 1'b0);
		push(make_pointer(OP_DELIVER, 0, 0, 0, 0, 0), 1'b1);
		push(make_call(FN_PRESS, 16'd7, 0, 0, 0), 1'b0);
		push(make_call(FN_RELEASE, 16'd2, 0, 0, 0), 1'b0);
		push(make_call(FN_WIN_X, 0, 16'd500, 16'hFFF0, 0), 1'b0);
		push(make_call(FN_WIN_Y, 0, 16'h8000, 16'h7FFF, 0), 1'b0);
		push(make_call(FN_SHOW, 0, 0, 0, 0), 1'b0);
		push(make_call(FN_SHOW, 0, 0, 0, 0), 1'b0);
		push(make_call(FN_HIDE, 0, 0, 0, 0), 1'b0);
		push(make_call(FN_MICKEYS, 0, 0, 0, 0), 1'b0);
		push(make_call(FN_SWAP_HDL, 0, 16'h0002, 16'h0, 16'h0), 1'b0);
		push(make_call(FN_SENS, 0, 0, 0, 0), 1'b0);
		push(make_call(FN_INFO, 0, 0, 0, 0), 1'b0);
		push(make_call(FN_SAVE_SIZE, 1, 2, 3, 4), 1'b0);
		push(make_call(FN_NOP_A, 5, 6, 7, 8), 1'b0);
		push(make_call(FN_SW_RESET, 0, 0, 0, 0), 1'b0);
		wait_drained();

		// random phases under several host sizes
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(REG_HOST_W, w_set[ph]);
			write_reg(REG_HOST_H, h_set[ph]);
			push(make_call(FN_RESET, 0, 0, 0, 0), 1'b0);
			push(make_call(FN_SET_HDL, 0, 16'h007F, 16'h0100, 16'h2000), 1'b0);
			// overflow the edge queue in one phase
			if (ph == 2) begin
				for (int k = 0; k < 70; k++)
					push(make_pointer(OP_MOTION, 16'(k * 9), 16'(k * 3), 0, 0, 0), 1'b0);
				push(make_pointer(OP_DELIVER, 0, 0, 0, 0, 0), 1'b0);
			end
			for (int k = 0; k < 50; k++) push(random_item(), $urandom_range(0, 60) == 0);
			push(make_pointer(OP_DELIVER, 0, 0, 0, 0, 0), 1'b0);
			wait_drained();
		end

		$display("items %0d, result beats %0d, handler callbacks %0d", items_sent,
			beats_seen, callbacks_seen);
		$display("host sizes swept from 0 to 8191, edge queue overflow and drain exercised");
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
